// File: rtl/core/lss_pkg.sv
// shared constants, types and state codes for the least-squares slope core
package lss_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LOG_N  = $clog2(MAX_POINTS);
    localparam int SX_W   = SAMPLE_BITS + LOG_N;
    localparam int SXY_W  = 2 * SAMPLE_BITS + LOG_N;
    localparam int SXX_W  = 2 * SAMPLE_BITS - 1 + LOG_N;
    localparam int NXY_W  = CNT_W + 1 + SXY_W;
    localparam int SQ_W   = 2 * SX_W;
    localparam int NXX_W  = CNT_W + SXX_W;
    localparam int NUM_W  = NXY_W + 1;
    localparam int DEN_W  = NXX_W + 1;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 33;
    localparam int DIV_STEPS = Q_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int OUT_W     = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic acc;
        logic mul;
        logic sub;
        logic chk;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic skip_div;
    } status_t;

endpackage

// File: rtl/core/lss_ctrl.sv
// sequencer for the least-squares slope core
module lss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last_pair,
    input  lss_pkg::status_t status,
    output logic             busy,
    output lss_pkg::cmd_t    cmd
);

    lss_pkg::state_t               state_reg;
    lss_pkg::state_t               state_next;
    logic [lss_pkg::STEP_W-1:0]    step_reg;
    logic [lss_pkg::STEP_W-1:0]    step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lss_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            lss_pkg::ST_IDLE:
            begin
                busy    = 1'b0;
                cmd.acc = start;
                if (start && last_pair)
                begin
                    state_next = lss_pkg::ST_MUL;
                end
            end
            lss_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = lss_pkg::ST_SUB;
            end
            lss_pkg::ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = lss_pkg::ST_CHK;
            end
            lss_pkg::ST_CHK:
            begin
                cmd.chk   = 1'b1;
                step_next = '0;
                if (status.skip_div)
                begin
                    state_next = lss_pkg::ST_DONE;
                end
                else
                begin
                    state_next = lss_pkg::ST_DIV;
                end
            end
            lss_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == lss_pkg::STEP_W'(lss_pkg::DIV_STEPS - 1))
                begin
                    state_next = lss_pkg::ST_DONE;
                end
            end
            lss_pkg::ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = lss_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lss_pkg::ST_IDLE;
            end
        endcase
    end

    // divider never runs past its last quotient bit
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lss_pkg::ST_DIV |-> step_reg < lss_pkg::STEP_W'(lss_pkg::DIV_STEPS))
        else $error("divider step count out of range");

    // a last pair always launches the solve sequence
    a_last_launch: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_pair |=> state_reg == lss_pkg::ST_MUL)
        else $error("last pair did not start the solve");

    // a finished set returns to idle right after the result is loaded
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lss_pkg::ST_DONE |=> state_reg == lss_pkg::ST_IDLE)
        else $error("sequencer stuck after finish");

endmodule

// File: rtl/core/lss_datapath.sv
// accumulators, cross products, fixed-point divider and result registers
module lss_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lss_pkg::cmd_t                          cmd,
    input  logic signed [lss_pkg::SAMPLE_BITS-1:0] x_value,
    input  logic signed [lss_pkg::SAMPLE_BITS-1:0] y_value,
    output lss_pkg::status_t                       status,
    output logic                                   done,
    output logic signed [lss_pkg::OUT_W-1:0]       slope,
    output logic                                   no_spread,
    output logic                                   saturated,
    output logic                                   overflowed,
    output logic [lss_pkg::CNT_W-1:0]              pair_count
);

    localparam int SB = lss_pkg::SAMPLE_BITS;
    localparam int DU = lss_pkg::DEN_W - 1;
    localparam int CW = DU + lss_pkg::FRAC_BITS + 1;

    // running sums
    logic [lss_pkg::CNT_W-1:0]        count_reg;
    logic signed [lss_pkg::SX_W-1:0]  sum_x_reg;
    logic signed [lss_pkg::SX_W-1:0]  sum_y_reg;
    logic signed [lss_pkg::SXY_W-1:0] sum_xy_reg;
    logic [lss_pkg::SXX_W-1:0]        sum_xx_reg;
    logic                             drop_reg;

    logic signed [2*SB-1:0] xy_prod;
    logic signed [2*SB-1:0] xx_prod;

    assign xy_prod = x_value * y_value;
    assign xx_prod = x_value * x_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (count_reg != lss_pkg::CNT_W'(lss_pkg::MAX_POINTS))
            begin
                count_reg  <= count_reg + 1'b1;
                sum_x_reg  <= sum_x_reg + lss_pkg::SX_W'(x_value);
                sum_y_reg  <= sum_y_reg + lss_pkg::SX_W'(y_value);
                sum_xy_reg <= sum_xy_reg + lss_pkg::SXY_W'(xy_prod);
                sum_xx_reg <= sum_xx_reg
                    + {{(lss_pkg::SXX_W - 2*SB + 1){1'b0}}, xx_prod[2*SB-2:0]};
            end
            else
            begin
                drop_reg <= 1'b1;
            end
        end
    end

    // cross products
    logic signed [lss_pkg::NXY_W-1:0] nxy_reg;
    logic signed [lss_pkg::SQ_W-1:0]  sxsy_reg;
    logic [lss_pkg::NXX_W-1:0]        nxx_reg;
    logic signed [lss_pkg::SQ_W-1:0]  sxsx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            nxy_reg  <= $signed({1'b0, count_reg}) * sum_xy_reg;
            sxsy_reg <= sum_x_reg * sum_y_reg;
            nxx_reg  <= count_reg * sum_xx_reg;
            sxsx_reg <= sum_x_reg * sum_x_reg;
        end
    end

    // numerator and spread term
    logic signed [lss_pkg::NUM_W-1:0] num_reg;
    logic signed [lss_pkg::DEN_W-1:0] den_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sub)
        begin
            num_reg <= lss_pkg::NUM_W'(nxy_reg) - lss_pkg::NUM_W'(sxsy_reg);
            den_reg <= $signed({1'b0, nxx_reg}) - lss_pkg::DEN_W'(sxsx_reg);
        end
    end

    // sign split and range check ahead of the divide
    logic                     neg_c;
    logic [lss_pkg::NUM_W-1:0] mag_c;
    logic                     flat_c;
    logic                     big_c;

    assign neg_c  = num_reg[lss_pkg::NUM_W-1];
    assign mag_c  = neg_c ? lss_pkg::NUM_W'(-num_reg) : lss_pkg::NUM_W'(num_reg);
    assign flat_c = den_reg[lss_pkg::DEN_W-1] || (den_reg == '0);
    // quotient needs more than 33 bits when mag >= den * 2^17
    assign big_c  = CW'(mag_c) >= {den_reg[DU-1:0], {(lss_pkg::FRAC_BITS + 1){1'b0}}};
    assign status.skip_div = flat_c || big_c;

    logic                           neg_reg;
    logic                           flat_reg;
    logic                           big_reg;
    logic [lss_pkg::DEN_W-1:0]      rem_reg;
    logic [lss_pkg::Q_W-1:0]        low_reg;
    logic [lss_pkg::Q_W-1:0]        q_reg;
    logic [lss_pkg::DEN_W-1:0]      trial;
    logic [lss_pkg::DEN_W-1:0]      den_u;
    logic                           fits;

    assign den_u = {1'b0, den_reg[DU-1:0]};
    assign trial = {rem_reg[lss_pkg::DEN_W-2:0], low_reg[lss_pkg::Q_W-1]};
    assign fits  = trial >= den_u;

    always_ff @(posedge clk)
    begin
        if (cmd.chk)
        begin
            neg_reg  <= neg_c;
            flat_reg <= flat_c;
            big_reg  <= big_c && !flat_c;
            rem_reg  <= lss_pkg::DEN_W'(mag_c >> (lss_pkg::FRAC_BITS + 1));
            low_reg  <= {mag_c[lss_pkg::FRAC_BITS:0], {lss_pkg::FRAC_BITS{1'b0}}};
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? (trial - den_u) : trial;
            low_reg <= {low_reg[lss_pkg::Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[lss_pkg::Q_W-2:0], fits};
        end
    end

    // final saturation and sign
    localparam logic [lss_pkg::Q_W-1:0] POS_LIM = lss_pkg::Q_W'(33'h0_7FFF_FFFF);
    localparam logic [lss_pkg::Q_W-1:0] NEG_LIM = lss_pkg::Q_W'(33'h0_8000_0000);

    logic                            sat_c;
    logic signed [lss_pkg::OUT_W-1:0] slope_c;

    always_comb
    begin
        sat_c = !flat_reg && (big_reg || (neg_reg ? (q_reg > NEG_LIM) : (q_reg > POS_LIM)));
        if (flat_reg)
        begin
            slope_c = '0;
        end
        else if (sat_c)
        begin
            slope_c = neg_reg ? {1'b1, {(lss_pkg::OUT_W-1){1'b0}}}
                              : {1'b0, {(lss_pkg::OUT_W-1){1'b1}}};
        end
        else if (neg_reg)
        begin
            slope_c = -$signed(q_reg[lss_pkg::OUT_W-1:0]);
        end
        else
        begin
            slope_c = $signed(q_reg[lss_pkg::OUT_W-1:0]);
        end
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            slope      <= slope_c;
            no_spread  <= flat_reg;
            saturated  <= sat_c;
            overflowed <= drop_reg;
            pair_count <= count_reg;
        end
    end

    assign done = done_reg;

    // results are at least a solve apart
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // flat spread and saturation never reported together
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(no_spread && saturated))
        else $error("no_spread and saturated both set");

    // sums are empty right after a result
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> count_reg == '0 && !drop_reg)
        else $error("accumulators not cleared after result");

endmodule

// File: rtl/core/least_squares_slope_core.sv
// top level of the least-squares slope core: sequencer plus datapath
// input rate: a pair that is not last is summed in its accept cycle and busy stays low,
//   so such pairs may arrive every cycle
// a last pair starts the solve: products, subtraction and range check, then the divider
//   (one quotient bit per cycle in a restore-divide unit), then a finish step;
//   done is registered from the finish step (the divider is skipped when spread is zero or
//   the quotient is out of range), and the next request may start the same cycle
// results cannot be stalled: done is a single-cycle strobe
// reset (rst_n low, asynchronous) clears the sums, count, drop flag and sequencer
module least_squares_slope_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [lss_pkg::SAMPLE_BITS-1:0] x_value,
    input  logic signed [lss_pkg::SAMPLE_BITS-1:0] y_value,
    input  logic                                   last_pair,
    output logic                                   done,
    output logic signed [lss_pkg::OUT_W-1:0]       slope,
    output logic                                   no_spread,
    output logic                                   saturated,
    output logic                                   overflowed,
    output logic [lss_pkg::CNT_W-1:0]              pair_count
);

    // command bundle from sequencer, status back from datapath
    lss_pkg::cmd_t    cmd;
    lss_pkg::status_t status;

    // state machine: accumulate, multiply, subtract, check, divide, finish
    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_pair (last_pair),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    // running sums, cross products, divider and result registers
    lss_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .x_value    (x_value),
        .y_value    (y_value),
        .status     (status),
        .done       (done),
        .slope      (slope),
        .no_spread  (no_spread),
        .saturated  (saturated),
        .overflowed (overflowed),
        .pair_count (pair_count)
    );

endmodule

// File: verif/tb_least_squares_slope_core.sv
// self-checking testbench for the least-squares slope core
`timescale 1ns / 1ps

module tb_least_squares_slope_core;

    // sender gaps and a solve are both far shorter than this limit, so a run of
    // cycles this long with no request or result accepted means the block has hung
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles to wait after the last result, in case a stray strobe follows
    localparam int TAIL_CYCLES    = 80;
    localparam int ITEM_TARGET    = 1900;

    // one fitted-line result as the block reports it
    typedef struct {
        logic [lss_pkg::OUT_W-1:0] slope;
        logic                      no_spread;
        logic                      saturated;
        logic                      overflowed;
        logic [lss_pkg::CNT_W-1:0] pair_count;
    } fit_t;

    // keeps its own copy of the running sums and predicts each fit
    class slope_tracker;
        int unsigned n_pairs;
        logic [63:0] sum_x;
        logic [63:0] sum_y;
        logic [63:0] sum_xy;
        logic [63:0] sum_xx;
        bit          dropped;
        fit_t        expected_fits[$];
        int          errors;

        function new();
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            n_pairs = 0;
            sum_x   = '0;
            sum_y   = '0;
            sum_xy  = '0;
            sum_xx  = '0;
            dropped = 1'b0;
        endfunction

        function int pending();
            return expected_fits.size();
        endfunction

        // an accepted request: add the pair, and on the last pair solve the fit
        function void note_pair(logic signed [lss_pkg::SAMPLE_BITS-1:0] x,
                                logic signed [lss_pkg::SAMPLE_BITS-1:0] y, logic last);
            longint       xs;
            longint       ys;
            logic [63:0]  n;
            logic [63:0]  num;
            logic [63:0]  den;
            logic [63:0]  mag;
            logic [127:0] q;
            logic         neg;
            fit_t         fit;
            xs = longint'(x);
            ys = longint'(y);
            if (n_pairs < lss_pkg::MAX_POINTS)
            begin
                n_pairs++;
                sum_x  += xs;
                sum_y  += ys;
                sum_xy += xs * ys;
                sum_xx += xs * xs;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!last)
                return;

            n   = 64'(n_pairs);
            num = n * sum_xy - sum_x * sum_y;
            den = n * sum_xx - sum_x * sum_x;
            fit = '{default: 0};
            fit.overflowed = dropped;
            fit.pair_count = n[lss_pkg::CNT_W-1:0];
            if (den == 0 || den[63])
            begin
                fit.no_spread = 1'b1;
            end
            else
            begin
                neg = num[63];
                mag = neg ? -num : num;
                // truncated quotient scaled by 2^16
                q = {48'd0, mag, 16'd0} / {64'd0, den};
                if (neg ? (q > 128'h8000_0000) : (q > 128'h7FFF_FFFF))
                begin
                    fit.saturated = 1'b1;
                    fit.slope     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    fit.slope = neg ? -q[31:0] : q[31:0];
                end
            end
            expected_fits.push_back(fit);
            clear_sums();
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // a result strobe: compare with the oldest predicted fit
        function void check_fit(fit_t got);
            fit_t want;
            if (expected_fits.size() == 0)
            begin
                $error("slope: expected no result, got 0x%0h", got.slope);
                errors++;
                return;
            end
            want = expected_fits.pop_front();
            compare_field("slope", 64'(want.slope), 64'(got.slope));
            compare_field("no_spread", 64'(want.no_spread), 64'(got.no_spread));
            compare_field("saturated", 64'(want.saturated), 64'(got.saturated));
            compare_field("overflowed", 64'(want.overflowed), 64'(got.overflowed));
            compare_field("pair_count", 64'(want.pair_count), 64'(got.pair_count));
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic signed [lss_pkg::SAMPLE_BITS-1:0] x_value;
    logic signed [lss_pkg::SAMPLE_BITS-1:0] y_value;
    logic                                   last_pair;
    logic                                   done;
    logic signed [lss_pkg::OUT_W-1:0]       slope;
    logic                                   no_spread;
    logic                                   saturated;
    logic                                   overflowed;
    logic [lss_pkg::CNT_W-1:0]              pair_count;

    slope_tracker tracker;
    int           items_sent;
    int           idle_cycles;

    least_squares_slope_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .y_value    (y_value),
        .last_pair  (last_pair),
        .done       (done),
        .slope      (slope),
        .no_spread  (no_spread),
        .saturated  (saturated),
        .overflowed (overflowed),
        .pair_count (pair_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // monitor: everything is sampled at the rising edge, before the block's
    // registers move, so busy here is the value that decided acceptance
    always @(posedge clk)
    begin : monitor
        fit_t got;
        if (rst_n)
        begin
            // check before noting: a request taken at this edge cannot be
            // the one whose result strobes at this edge
            if (done)
            begin
                got.slope      = slope;
                got.no_spread  = no_spread;
                got.saturated  = saturated;
                got.overflowed = overflowed;
                got.pair_count = pair_count;
                tracker.check_fit(got);
            end
            if (start && !busy)
                tracker.note_pair(x_value, y_value, last_pair);
        end
    end

    // watchdog: counts cycles with neither a request nor a result accepted
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one request at the falling edge and hold it until taken;
    // the caller follows with another request or a pause, so start never
    // lingers high into an unintended edge
    task automatic send_pair(input int x, input int y, input logic last);
        @(negedge clk);
        start     <= 1'b1;
        x_value   <= x[lss_pkg::SAMPLE_BITS-1:0];
        y_value   <= y[lss_pkg::SAMPLE_BITS-1:0];
        last_pair <= last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // start low for the given number of cycles, junk on the fields
    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start     <= 1'b0;
            x_value   <= lss_pkg::SAMPLE_BITS'($urandom);
            y_value   <= lss_pkg::SAMPLE_BITS'($urandom);
            last_pair <= 1'($urandom);
        end
    endtask

    // hold off the sender until every predicted fit has come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending() > 0)
            @(negedge clk);
    endtask

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    function automatic int extreme_sample();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    // one set of pairs ending on a last pair; the content style varies so
    // that random noise, flat sets, clean lines and range edges all show up
    task automatic send_set(input int len, input int style);
        int line_gain;
        int line_offset;
        int fixed_x;
        int xi;
        int yi;
        bit gapless;
        line_gain   = $urandom_range(0, 40) - 20;
        line_offset = $urandom_range(0, 2000) - 1000;
        fixed_x     = $urandom;
        gapless     = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0:
                begin
                    xi = $urandom;
                    yi = $urandom;
                end
                1:
                begin
                    // tiny values: often no spread in short sets
                    xi = $urandom_range(0, 16) - 8;
                    yi = $urandom_range(0, 16) - 8;
                end
                2:
                begin
                    // noisy straight line, gives mid-range slopes
                    xi = $urandom_range(0, 400) - 200;
                    yi = line_gain * xi + line_offset + $urandom_range(0, 6) - 3;
                end
                3:
                begin
                    // every x the same: zero spread
                    xi = fixed_x;
                    yi = $urandom;
                end
                default:
                begin
                    xi = extreme_sample();
                    yi = extreme_sample();
                end
            endcase
            send_pair(xi, yi, i == len - 1);
            if (!gapless)
                pause(random_gap());
        end
    endtask

    initial
    begin
        bit full_set_sent;
        tracker       = new();
        items_sent    = 0;
        full_set_sent = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        x_value       = '0;
        y_value       = '0;
        last_pair     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single pair: no spread
        send_pair(5, 7, 1'b1);
        // all x equal at the most negative value: no spread
        send_pair(-32768, 3, 1'b0);
        send_pair(-32768, -32768, 1'b0);
        send_pair(-32768, 32767, 1'b1);
        // sample extremes, slope of exactly one
        send_pair(-32768, -32768, 1'b0);
        send_pair(32767, 32767, 1'b1);
        // sample extremes, slope of exactly minus one
        send_pair(32767, -32768, 1'b0);
        send_pair(-32768, 32767, 1'b1);
        // quotient of exactly -32768.0, the one negative edge that fits
        send_pair(0, 0, 1'b0);
        send_pair(1, -32768, 1'b1);
        // +32768.0 does not fit: saturates high
        send_pair(0, -32768, 1'b0);
        send_pair(1, 0, 1'b1);
        // far below range: saturates low
        send_pair(0, 32767, 1'b0);
        send_pair(1, -32768, 1'b1);
        // -1/3: truncation toward zero on a negative fraction
        send_pair(0, 0, 1'b0);
        send_pair(3, -1, 1'b1);
        // +2/3 with a gap before the last pair
        send_pair(0, 0, 1'b0);
        pause(3);
        send_pair(3, 2, 1'b1);

        // sender waits for every result before the random part
        drain();

        while (items_sent < ITEM_TARGET)
        begin
            if (!full_set_sent && items_sent > 500)
            begin
                // fill the set past capacity; the last pair itself is dropped
                send_set(lss_pkg::MAX_POINTS + $urandom_range(1, 4), $urandom_range(0, 4));
                full_set_sent = 1'b1;
            end
            else if ($urandom_range(0, 99) < 85)
            begin
                send_set($urandom_range(1, 12), $urandom_range(0, 4));
            end
            else
            begin
                send_set($urandom_range(13, 40), $urandom_range(0, 4));
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lss_pkg.sv
rtl/core/lss_ctrl.sv
rtl/core/lss_datapath.sv
rtl/core/least_squares_slope_core.sv
verif/tb_least_squares_slope_core.sv
